@@ src/mcsnr_pkg.sv @@
// Shared widths, defaults and register codes for the mel channel noise reducer.
package mcsnr_pkg;

	localparam int ENERGY_W  = 64;
	localparam int ROOT_W    = 32;
	localparam int WEIGHT_W  = 15;
	localparam int CH_IDX_W  = 6;
	localparam int SHIFT_W   = 4;
	localparam int CFG_IDX_W = 3;

	localparam int CHANNELS_DEF     = 40;
	localparam int SMOOTH_SHIFT_DEF = 10;
	localparam int SUB_SHIFT_DEF    = 14;

	localparam logic [WEIGHT_W-1:0] EVEN_SMOOTH_RST = 15'd410;
	localparam logic [WEIGHT_W-1:0] ODD_SMOOTH_RST  = 15'd983;
	localparam logic [WEIGHT_W-1:0] EVEN_KEEP_RST   = 15'd15974;
	localparam logic [WEIGHT_W-1:0] ODD_KEEP_RST    = 15'd15401;
	localparam logic [WEIGHT_W-1:0] MIN_FRAC_RST    = 15'd819;

	// rounding caps: no round-up once the root already sits at these
	localparam logic [ROOT_W-1:0] SMALL_CAP = 32'h0000_FFFF;
	localparam logic [ROOT_W-1:0] WIDE_CAP  = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EVEN_SMOOTH = 3'd0,
		REG_ODD_SMOOTH  = 3'd1,
		REG_EVEN_KEEP   = 3'd2,
		REG_ODD_KEEP    = 3'd3,
		REG_MIN_FRAC    = 3'd4
	} cfg_reg_t;

endpackage

@@ src/mcsnr_sqrt.sv @@
// Iterative bit-pair square root, 64-bit operand, rounded 32-bit root.
module mcsnr_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mcsnr_pkg::ENERGY_W-1:0] operand,
	output logic                           done,
	output logic [mcsnr_pkg::ROOT_W-1:0]   root
);
	import mcsnr_pkg::*;

	localparam int ITERS = ENERGY_W / 2;
	localparam int CNT_W = $clog2(ITERS);

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_RND
	} sq_state_t;

	sq_state_t             state_q;
	logic [ENERGY_W-1:0]   v_q;
	logic [ENERGY_W-1:0]   r_q;
	logic [ENERGY_W-1:0]   b_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  small_q;
	logic                  done_q;
	logic [ROOT_W-1:0]     root_q;

	logic [ENERGY_W:0]     trial;
	logic                  take;
	logic [ROOT_W-1:0]     cap;
	logic                  rnd;

	assign trial = {1'b0, r_q} + {1'b0, b_q};
	assign take  = {1'b0, v_q} >= trial;
	assign cap   = small_q ? SMALL_CAP : WIDE_CAP;
	// round to nearest: remainder above the root means v >= r*r + r + 1
	assign rnd   = (v_q > r_q) && (r_q[ROOT_W-1:0] != cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			v_q     <= '0;
			r_q     <= '0;
			b_q     <= '0;
			cnt_q   <= '0;
			small_q <= 1'b0;
			done_q  <= 1'b0;
			root_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SQ_IDLE: begin
					if (start) begin
						v_q     <= operand;
						r_q     <= '0;
						b_q     <= {2'b01, {(ENERGY_W-2){1'b0}}};
						cnt_q   <= '0;
						small_q <= (operand[ENERGY_W-1:ROOT_W] == '0);
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					if (take) begin
						v_q <= v_q - trial[ENERGY_W-1:0];
						r_q <= (r_q >> 1) + b_q;
					end else begin
						r_q <= r_q >> 1;
					end
					b_q   <= b_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ITERS - 1)) begin
						state_q <= SQ_RND;
					end
				end
				SQ_RND: begin
					root_q  <= r_q[ROOT_W-1:0] + ROOT_W'(rnd);
					done_q  <= 1'b1;
					state_q <= SQ_IDLE;
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ src/mel_channel_sqrt_noise_reduce_core.sv @@
// Mel channel square root and spectral-subtraction noise reduction, top level.
//
// Input channel (in_valid/in_ready): one request carries a channel's 64-bit
// filterbank energy, its channel index and the frame's scale shift.
// Output channel (out_valid/out_ready): one result per request, the scaled
// rounded root and the noise-reduced magnitude.
// Config channel (cfg_valid/cfg_ready): writes one 15-bit weight register by
// index; always ready. Write only while no request is in flight.
// Each request passes through the bit-pair square root unit (32 iterations
// and a rounding step), then through three passes of one shared 32x15
// multiplier; a new request is taken only once the previous one has left
// the final step.
// The output sits in its own register, so a new request is taken while a
// result waits; if the receiver stalls, the next result holds in the final
// step and in_ready stays low until the output register frees up.
// Reset clears all noise estimates (per-channel valid bits) and loads the
// default weights; no clearing pass is needed.
module mel_channel_sqrt_noise_reduce_core #(
	parameter int CHANNELS     = mcsnr_pkg::CHANNELS_DEF,
	parameter int SMOOTH_SHIFT = mcsnr_pkg::SMOOTH_SHIFT_DEF,
	parameter int SUB_SHIFT    = mcsnr_pkg::SUB_SHIFT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mcsnr_pkg::ENERGY_W-1:0]  channel_energy,
	input  logic [mcsnr_pkg::CH_IDX_W-1:0]  channel_index,
	input  logic [mcsnr_pkg::SHIFT_W-1:0]   scale_shift,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mcsnr_pkg::ROOT_W-1:0]    scaled_root,
	output logic [mcsnr_pkg::ROOT_W-1:0]    reduced_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mcsnr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcsnr_pkg::WEIGHT_W-1:0]  cfg_data
);
	import mcsnr_pkg::*;

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W = ROOT_W + WEIGHT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_M1,
		S_M2,
		S_M3,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic                 odd_q;
	logic                 idx_ok_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 old_vld_q;
	logic [ROOT_W-1:0]    old_rd_q;
	logic [ROOT_W-1:0]    root_q;
	logic [PROD_W-1:0]    prod_q;
	logic [ROOT_W-1:0]    p1_q;
	logic [ROOT_W-1:0]    est_q;
	logic                 out_valid_q;
	logic [ROOT_W-1:0]    out_root_q;
	logic [ROOT_W-1:0]    out_red_q;

	logic [WEIGHT_W-1:0]  even_smooth_q;
	logic [WEIGHT_W-1:0]  odd_smooth_q;
	logic [WEIGHT_W-1:0]  even_keep_q;
	logic [WEIGHT_W-1:0]  odd_keep_q;
	logic [WEIGHT_W-1:0]  min_frac_q;

	logic [ROOT_W-1:0]    est_mem [CHANNELS];
	logic [CHANNELS-1:0]  est_vld_q;

	logic                 in_acc;
	logic                 in_idx_ok;
	logic [IDX_W-1:0]     in_idx;
	logic                 sq_done;
	logic [ROOT_W-1:0]    sq_root;
	logic [ROOT_W-1:0]    up;
	logic [ROOT_W-1:0]    old_est;
	logic [ROOT_W-1:0]    new_est;
	logic [ROOT_W-1:0]    flr;
	logic [ROOT_W-1:0]    est_clamp;
	logic [ROOT_W-1:0]    sub;
	logic [ROOT_W-1:0]    red;
	logic [PROD_W-1:0]    flr_full;
	logic [ROOT_W-1:0]    mul_a;
	logic [WEIGHT_W-1:0]  mul_b;
	logic                 mem_we;
	logic                 out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_idx_ok = {1'b0, channel_index} < (CH_IDX_W + 1)'(CHANNELS);
	assign in_idx    = channel_index[IDX_W-1:0];
	assign cfg_ready = 1'b1;

	mcsnr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.operand (channel_energy),
		.done    (sq_done),
		.root    (sq_root)
	);

	// datapath around the shared multiplier
	assign up        = ROOT_W'(root_q << SMOOTH_SHIFT);
	assign old_est   = old_vld_q ? old_rd_q : '0;
	assign new_est   = (p1_q + prod_q[ROOT_W-1:0]) >> SUB_SHIFT;
	assign flr_full  = prod_q >> SUB_SHIFT;
	assign flr       = flr_full[ROOT_W-1:0];
	assign est_clamp = (est_q > up) ? up : est_q;
	assign sub       = (up - est_clamp) >> SMOOTH_SHIFT;
	assign red       = (sub > flr) ? sub : flr;
	assign mem_we    = (state_q == S_M3) && idx_ok_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		mul_a = root_q;
		mul_b = min_frac_q;
		case (state_q)
			S_M1: begin
				mul_a = up;
				mul_b = odd_q ? odd_smooth_q : even_smooth_q;
			end
			S_M2: begin
				mul_a = old_est;
				mul_b = odd_q ? odd_keep_q : even_keep_q;
			end
			default: begin
				mul_a = root_q;
				mul_b = min_frac_q;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_smooth_q <= EVEN_SMOOTH_RST;
			odd_smooth_q  <= ODD_SMOOTH_RST;
			even_keep_q   <= EVEN_KEEP_RST;
			odd_keep_q    <= ODD_KEEP_RST;
			min_frac_q    <= MIN_FRAC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_EVEN_SMOOTH: even_smooth_q <= cfg_data;
				REG_ODD_SMOOTH:  odd_smooth_q  <= cfg_data;
				REG_EVEN_KEEP:   even_keep_q   <= cfg_data;
				REG_ODD_KEEP:    odd_keep_q    <= cfg_data;
				REG_MIN_FRAC:    min_frac_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// noise estimate store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			est_mem[idx_q] <= new_est;
		end
		if (in_acc) begin
			old_rd_q <= est_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_vld_q <= '0;
		end else if (mem_we) begin
			est_vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			shift_q     <= '0;
			odd_q       <= 1'b0;
			idx_ok_q    <= 1'b0;
			idx_q       <= '0;
			old_vld_q   <= 1'b0;
			root_q      <= '0;
			prod_q      <= '0;
			p1_q        <= '0;
			est_q       <= '0;
			out_valid_q <= 1'b0;
			out_root_q  <= '0;
			out_red_q   <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						shift_q   <= scale_shift;
						odd_q     <= channel_index[0];
						idx_ok_q  <= in_idx_ok;
						idx_q     <= in_idx;
						old_vld_q <= in_idx_ok && est_vld_q[in_idx];
						state_q   <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						root_q  <= sq_root >> shift_q;
						state_q <= S_M1;
					end
				end
				S_M1: begin
					prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= S_M2;
				end
				S_M2: begin
					p1_q    <= prod_q[ROOT_W-1:0];
					prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= S_M3;
				end
				S_M3: begin
					est_q   <= new_est;
					prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_root_q  <= root_q;
						out_red_q   <= red;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign scaled_root   = out_root_q;
	assign reduced_value = out_red_q;

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_ROOT))
		else $error("accepted request did not start the root");

	a_sqrt_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == S_ROOT))
		else $error("root finished outside the root step");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, idx_q} < (IDX_W + 1)'(CHANNELS)))
		else $error("noise estimate write out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_red_q)))
		else $error("pending result overwritten");

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for the mel channel square root and noise reduction core.
module tb_top;
	import mcsnr_pkg::*;

	localparam int CHANNELS       = CHANNELS_DEF;
	localparam int SMOOTH_SHIFT   = SMOOTH_SHIFT_DEF;
	localparam int SUB_SHIFT      = SUB_SHIFT_DEF;
	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int PHASES         = 8;
	localparam int FRAMES         = 5;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 15'd16384;
	localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 15'h7FFF;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_mode_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [CH_IDX_W-1:0] ch;
		logic [SHIFT_W-1:0]  sh;
		logic                fixed_want;
		logic [ROOT_W-1:0]   want_root;
		logic [ROOT_W-1:0]   want_red;
	} mel_req_t;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] red;
	} mel_result_t;

	// directed rows; the first four carry hand-worked results at reset weights
	localparam int DIRECTED_ROWS = 23;
	localparam mel_req_t DIRECTED [DIRECTED_ROWS] = '{
		'{64'd0,                  6'd0,  4'd0,  1'b1, 32'd0, 32'd0},
		'{64'd1,                  6'd1,  4'd0,  1'b1, 32'd1, 32'd0},
		'{64'd4,                  6'd40, 4'd0,  1'b1, 32'd2, 32'd1},
		'{64'd0,                  6'd63, 4'd15, 1'b1, 32'd0, 32'd0},
		'{64'd3,                  6'd0,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'd12,                 6'd2,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'd13,                 6'd3,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFE_0001,          6'd4,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFF_0000,          6'd5,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFF,          6'd6,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'h1_0000_0000,        6'd7,  4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFE_0000_0001, 6'd8, 4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFF_0000_0000, 6'd9, 4'd0,  1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 4'd0, 1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 6'd11, 4'd15, 1'b0, 32'd0, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 6'd38, 4'd7, 1'b0, 32'd0, 32'd0},
		'{64'h5555_5555_5555_5555, 6'd39, 4'd3, 1'b0, 32'd0, 32'd0},
		'{64'h1234_5678_9ABC_DEF0, 6'd39, 4'd0, 1'b0, 32'd0, 32'd0},
		'{64'h1234_5678_9ABC_DEF0, 6'd39, 4'd0, 1'b0, 32'd0, 32'd0},
		'{64'h1234_5678_9ABC_DEF0, 6'd39, 4'd0, 1'b0, 32'd0, 32'd0},
		'{64'd1000000,            6'd20, 4'd1,  1'b0, 32'd0, 32'd0},
		'{64'd1000000,            6'd20, 4'd1,  1'b0, 32'd0, 32'd0},
		'{64'd1000000,            6'd62, 4'd2,  1'b0, 32'd0, 32'd0}
	};

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [ENERGY_W-1:0] channel_energy = '0;
	logic [CH_IDX_W-1:0] channel_index  = '0;
	logic [SHIFT_W-1:0]  scale_shift    = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [ROOT_W-1:0]   scaled_root;
	logic [ROOT_W-1:0]   reduced_value;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	cfg_reg_t            cfg_index      = REG_EVEN_SMOOTH;
	logic [WEIGHT_W-1:0] cfg_data       = '0;

	// model of the block's state and weights
	logic [ROOT_W-1:0]   noise_est [CHANNELS];
	logic [WEIGHT_W-1:0] w_even_smooth = EVEN_SMOOTH_RST;
	logic [WEIGHT_W-1:0] w_odd_smooth  = ODD_SMOOTH_RST;
	logic [WEIGHT_W-1:0] w_even_keep   = EVEN_KEEP_RST;
	logic [WEIGHT_W-1:0] w_odd_keep    = ODD_KEEP_RST;
	logic [WEIGHT_W-1:0] w_min_frac    = MIN_FRAC_RST;

	mel_req_t    pending_reqs [$];
	mel_result_t expected_results [$];
	mel_req_t    cur_req;
	pace_mode_t  pace = PACE_FULL;

	bit in_taken, out_taken, cfg_taken, flow_empty;
	int mismatches, results_checked, reqs_accepted, stray_reqs, reg_writes, quiet_cycles;

	always #HALF_PERIOD clk = ~clk;

	mel_channel_sqrt_noise_reduce_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.channel_energy(channel_energy),
		.channel_index (channel_index),
		.scale_shift   (scale_shift),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scaled_root   (scaled_root),
		.reduced_value (reduced_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		for (int i = 0; i < CHANNELS; i++) noise_est[i] = '0;
	end

	function automatic logic [ENERGY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// bit-pair square root, rounded to nearest unless the root sits at its cap
	function automatic logic [ROOT_W-1:0] rounded_root(logic [ENERGY_W-1:0] e);
		logic [ENERGY_W-1:0] rem, r, b;
		logic [ROOT_W-1:0]   cap;
		rem = e;
		r   = '0;
		b   = 64'h4000_0000_0000_0000;
		cap = (e[63:32] == '0) ? SMALL_CAP : WIDE_CAP;
		while (b > rem) b = b >> 2;
		while (b != '0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (rem > r && r[ROOT_W-1:0] != cap) r = r + 1;
		return r[ROOT_W-1:0];
	endfunction

	// computes one result and advances the channel's noise estimate (in-range channels only)
	function automatic mel_result_t reduce_channel(logic [ENERGY_W-1:0] e,
			logic [CH_IDX_W-1:0] ch, logic [SHIFT_W-1:0] sh);
		logic [ROOT_W-1:0]   root, up, p1, p2, sum, old_est, new_est, est, flr, sub;
		logic [WEIGHT_W-1:0] smooth, keep;
		logic [63:0]         wide;
		bit                  in_range;
		mel_result_t         res;
		in_range = ch < CHANNELS;
		root     = rounded_root(e) >> sh;
		smooth   = ch[0] ? w_odd_smooth : w_even_smooth;
		keep     = ch[0] ? w_odd_keep : w_even_keep;
		old_est  = in_range ? noise_est[ch] : '0;
		up       = root << SMOOTH_SHIFT;
		wide     = 64'(up) * 64'(smooth);
		p1       = wide[31:0];
		wide     = 64'(old_est) * 64'(keep);
		p2       = wide[31:0];
		sum      = p1 + p2;
		new_est  = sum >> SUB_SHIFT;
		if (in_range) noise_est[ch] = new_est;
		est      = (new_est > up) ? up : new_est;
		wide     = (64'(root) * 64'(w_min_frac)) >> SUB_SHIFT;
		flr      = wide[31:0];
		sub      = (up - est) >> SMOOTH_SHIFT;
		res.root = root;
		res.red  = (sub > flr) ? sub : flr;
		return res;
	endfunction

	function automatic bit pace_hold(bit sender_side);
		case (pace)
			PACE_SEND_GAPS:   return sender_side && $urandom_range(0, 99) < 61;
			PACE_RECV_STALLS: return !sender_side && $urandom_range(0, 99) < 61;
			PACE_BOTH:        return $urandom_range(0, 99) < 27;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic mel_req_t make_req(logic [ENERGY_W-1:0] e, logic [CH_IDX_W-1:0] ch,
			logic [SHIFT_W-1:0] sh);
		mel_req_t rq;
		rq            = '0;
		rq.energy     = e;
		rq.ch         = ch;
		rq.sh         = sh;
		return rq;
	endfunction

	function automatic logic [ENERGY_W-1:0] pick_energy();
		logic [ENERGY_W-1:0] r;
		r = {32'b0, $urandom} >> $urandom_range(0, 31);
		case ($urandom_range(0, 6))
			0:       return 64'($urandom_range(0, 1023));
			1:       return {32'b0, $urandom};
			2:       return rand64() >> $urandom_range(0, 63);
			3:       return r * r + (($urandom_range(0, 1) == 1) ? r : r + 1);
			4:       return r * r - 64'($urandom_range(0, 1));
			5:       return rand64();
			default: return ($urandom_range(0, 1) == 1) ? 64'hFFFF_FFFF : '1;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [ROOT_W-1:0] want, logic [ROOT_W-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// sender: hold the request until taken, then maybe gap before the next
	always @(posedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && pending_reqs.size() != 0 && !pace_hold(1'b1)) begin
				cur_req = pending_reqs.pop_front();
				in_valid       <= 1'b1;
				channel_energy <= cur_req.energy;
				channel_index  <= cur_req.ch;
				scale_shift    <= cur_req.sh;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= !pace_hold(1'b0);
	end

	// everything sampled at the falling edge, between driving edges
	always @(negedge clk) begin
		mel_result_t want, got;
		in_taken  = arst_n && in_valid && in_ready;
		out_taken = arst_n && out_valid && out_ready;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (cfg_taken) begin
			reg_writes++;
			case (cfg_index)
				REG_EVEN_SMOOTH: w_even_smooth = cfg_data;
				REG_ODD_SMOOTH:  w_odd_smooth  = cfg_data;
				REG_EVEN_KEEP:   w_even_keep   = cfg_data;
				REG_ODD_KEEP:    w_odd_keep    = cfg_data;
				REG_MIN_FRAC:    w_min_frac    = cfg_data;
				default: ;
			endcase
		end
		if (in_taken) begin
			want = reduce_channel(cur_req.energy, cur_req.ch, cur_req.sh);
			if (cur_req.fixed_want) want = {cur_req.want_root, cur_req.want_red};
			expected_results.push_back(want);
			reqs_accepted++;
			if (cur_req.ch >= CHANNELS) stray_reqs++;
		end
		if (out_taken) begin
			got = {scaled_root, reduced_value};
			if (expected_results.size() == 0) begin
				report_mismatch("unrequested result root", '0, got.root);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got.root !== want.root) report_mismatch("scaled_root", want.root, got.root);
				if (got.red !== want.red) report_mismatch("reduced_value", want.red, got.red);
			end
		end
		flow_empty = pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0;
	end

	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t r, logic [WEIGHT_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_weights(logic [WEIGHT_W-1:0] es, logic [WEIGHT_W-1:0] os,
			logic [WEIGHT_W-1:0] ek, logic [WEIGHT_W-1:0] ok, logic [WEIGHT_W-1:0] mf);
		write_reg(REG_EVEN_SMOOTH, es);
		write_reg(REG_ODD_SMOOTH, os);
		write_reg(REG_EVEN_KEEP, ek);
		write_reg(REG_ODD_KEEP, ok);
		write_reg(REG_MIN_FRAC, mf);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		do @(posedge clk); while (!flow_empty);
	endtask

	// frames walk the channels in order with a steady per-channel level;
	// stray requests and skipped channels break the pattern now and then
	task automatic queue_frames(int frames);
		logic [ENERGY_W-1:0] level [CHANNELS];
		logic [ENERGY_W-1:0] jit;
		logic [SHIFT_W-1:0]  sh;
		for (int c = 0; c < CHANNELS; c++) level[c] = pick_energy();
		for (int f = 0; f < frames; f++) begin
			sh = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
			for (int c = 0; c < CHANNELS; c++) begin
				if ($urandom_range(0, 99) < 10)
					pending_reqs.push_back(make_req(pick_energy(), 6'($urandom_range(0, 63)),
						4'($urandom_range(0, 15))));
				if ($urandom_range(0, 99) < 5) continue;
				if ($urandom_range(0, 99) < 3) level[c] = pick_energy();
				jit = level[c] >> $urandom_range(1, 6);
				pending_reqs.push_back(make_req(level[c] - jit + rand64() % (2 * jit + 1),
					6'(c), sh));
			end
		end
	endtask

	initial begin
		logic [WEIGHT_W-1:0] se, so;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) pending_reqs.push_back(DIRECTED[i]);
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				case (p)
					1: load_weights('0, '0, '0, '0, '0);
					2: load_weights(WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE);
					3: load_weights(WEIGHT_TOP, WEIGHT_TOP, WEIGHT_TOP, WEIGHT_TOP, WEIGHT_TOP);
					4: begin
						se = 15'($urandom_range(0, 16384));
						so = 15'($urandom_range(0, 16384));
						load_weights(se, so, WEIGHT_ONE - se, WEIGHT_ONE - so,
							15'($urandom_range(0, 16384)));
					end
					5: load_weights(15'($urandom), 15'($urandom), 15'($urandom),
						15'($urandom), 15'($urandom));
					6: load_weights(WEIGHT_ONE, '0, '0, WEIGHT_ONE, WEIGHT_ONE);
					default: load_weights(EVEN_SMOOTH_RST, ODD_SMOOTH_RST, EVEN_KEEP_RST,
						ODD_KEEP_RST, MIN_FRAC_RST);
				endcase
				@(negedge clk);
			end
			pace = pace_mode_t'(p % 4);
			queue_frames(FRAMES);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d on channels past the last) over %0d weight sets",
			reqs_accepted, stray_reqs, PHASES);
		$display("%0d results checked, %0d register writes, %0d mismatches",
			results_checked, reg_writes, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
